[rtl/rcps_pkg.sv]
// ----------------------------------------------------------------------------
// rcps_pkg
// Item types, configuration register set and constants for the rc pulse
// relay switch with failsafe.
// ----------------------------------------------------------------------------
`default_nettype none

package rcps_pkg;

  localparam int WIDTH_BITS = 15;
  localparam int TIMEOUT_BITS = 16;
  localparam int NOW_BITS = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_FLOOR = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VALID_LOW = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VALID_HIGH = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_WIDTH = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ARM_DEADBAND = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ON_THRESHOLD = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFF_THRESHOLD = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT_MS = 3'd7;

  // reset values
  localparam logic [WIDTH_BITS-1:0] RST_HOLD_FLOOR = 15'd500;
  localparam logic [WIDTH_BITS-1:0] RST_VALID_LOW = 15'd900;
  localparam logic [WIDTH_BITS-1:0] RST_VALID_HIGH = 15'd2100;
  localparam logic [WIDTH_BITS-1:0] RST_CENTER_WIDTH = 15'd1500;
  localparam logic [WIDTH_BITS-1:0] RST_ARM_DEADBAND = 15'd100;
  localparam logic [WIDTH_BITS-1:0] RST_ON_THRESHOLD = 15'd1700;
  localparam logic [WIDTH_BITS-1:0] RST_OFF_THRESHOLD = 15'd1300;
  localparam logic [TIMEOUT_BITS-1:0] RST_TIMEOUT_MS = 16'd500;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] width_a;
    logic [WIDTH_BITS-1:0] width_b;
    logic [WIDTH_BITS-1:0] width_c;
    logic [NOW_BITS-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic relay_one;
    logic relay_two;
    logic relay_three;
    logic relay_four;
    logic armed;
    logic signal_ok;
  } out_item_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]   hold_floor;
    logic [WIDTH_BITS-1:0]   valid_low;
    logic [WIDTH_BITS-1:0]   valid_high;
    logic [WIDTH_BITS-1:0]   center_width;
    logic [WIDTH_BITS-1:0]   arm_deadband;
    logic [WIDTH_BITS-1:0]   on_threshold;
    logic [WIDTH_BITS-1:0]   off_threshold;
    logic [TIMEOUT_BITS-1:0] timeout_ms;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/rcps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rcps_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rcps_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [rcps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [rcps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output rcps_pkg::cfg_t                           cfg
);

  rcps_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.hold_floor    <= rcps_pkg::RST_HOLD_FLOOR;
      regs.valid_low     <= rcps_pkg::RST_VALID_LOW;
      regs.valid_high    <= rcps_pkg::RST_VALID_HIGH;
      regs.center_width  <= rcps_pkg::RST_CENTER_WIDTH;
      regs.arm_deadband  <= rcps_pkg::RST_ARM_DEADBAND;
      regs.on_threshold  <= rcps_pkg::RST_ON_THRESHOLD;
      regs.off_threshold <= rcps_pkg::RST_OFF_THRESHOLD;
      regs.timeout_ms    <= rcps_pkg::RST_TIMEOUT_MS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rcps_pkg::REG_HOLD_FLOOR:    regs.hold_floor    <= cfg_data[rcps_pkg::WIDTH_BITS-1:0];
        rcps_pkg::REG_VALID_LOW:     regs.valid_low     <= cfg_data[rcps_pkg::WIDTH_BITS-1:0];
        rcps_pkg::REG_VALID_HIGH:    regs.valid_high    <= cfg_data[rcps_pkg::WIDTH_BITS-1:0];
        rcps_pkg::REG_CENTER_WIDTH:  regs.center_width  <= cfg_data[rcps_pkg::WIDTH_BITS-1:0];
        rcps_pkg::REG_ARM_DEADBAND:  regs.arm_deadband  <= cfg_data[rcps_pkg::WIDTH_BITS-1:0];
        rcps_pkg::REG_ON_THRESHOLD:  regs.on_threshold  <= cfg_data[rcps_pkg::WIDTH_BITS-1:0];
        rcps_pkg::REG_OFF_THRESHOLD: regs.off_threshold <= cfg_data[rcps_pkg::WIDTH_BITS-1:0];
        rcps_pkg::REG_TIMEOUT_MS:    regs.timeout_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

[rtl/rcps_core.sv]
// ----------------------------------------------------------------------------
// rcps_core
// Held widths, failsafe timer, arming flag and relay latches; computes the
// result of one item and updates the state in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcps_core #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire rcps_pkg::in_item_t  item,
  input  wire rcps_pkg::cfg_t      cfg,
  output rcps_pkg::out_item_t      result
);

  localparam int WB = rcps_pkg::WIDTH_BITS;

  logic [WB-1:0]         held [3];
  logic [WB-1:0]         held_next [3];
  logic [TIME_WIDTH-1:0] last_good;
  logic [TIME_WIDTH-1:0] last_good_next;
  logic                  armed;
  logic                  armed_next;
  logic [1:0]            latch;
  logic [1:0]            latch_next;

  logic [WB-1:0]         meas [3];
  logic [WB-1:0]         w [3];
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  valid;
  logic                  timeout;
  logic                  any_off_centre;
  logic                  armed_kept;
  logic                  r3;
  logic                  r4;

  function automatic logic in_window(logic [WB-1:0] x, logic [WB-1:0] lo,
                                     logic [WB-1:0] hi);
    return (x > lo) && (x < hi);
  endfunction

  function automatic logic off_centre(logic [WB-1:0] x, logic [WB-1:0] c,
                                      logic [WB-1:0] band);
    logic [WB-1:0] d;
    d = (x >= c) ? (x - c) : (c - x);
    return d > band;
  endfunction

  always_comb begin
    meas[0] = item.width_a;
    meas[1] = item.width_b;
    meas[2] = item.width_c;
    for (int i = 0; i < 3; i++) begin
      w[i] = (meas[i] > cfg.hold_floor) ? meas[i] : held[i];
    end

    now_t = TIME_WIDTH'(item.now_ms);
    valid = in_window(w[0], cfg.valid_low, cfg.valid_high) &&
            in_window(w[1], cfg.valid_low, cfg.valid_high) &&
            in_window(w[2], cfg.valid_low, cfg.valid_high);
    last_good_next = valid ? now_t : last_good;
    elapsed = now_t - last_good_next;
    timeout = elapsed > TIME_WIDTH'(cfg.timeout_ms);

    for (int i = 0; i < 3; i++) begin
      held_next[i] = timeout ? cfg.center_width : w[i];
    end

    // arming test looks at the widths from before the failsafe recentering
    any_off_centre = off_centre(w[0], cfg.center_width, cfg.arm_deadband) ||
                     off_centre(w[1], cfg.center_width, cfg.arm_deadband) ||
                     off_centre(w[2], cfg.center_width, cfg.arm_deadband);
    armed_kept = armed && !timeout;
    armed_next = armed_kept || (valid && any_off_centre);

    latch_next = latch;
    r3 = 1'b0;
    r4 = 1'b0;
    if (!valid || !armed_next) begin
      latch_next = 2'b00;
    end else begin
      for (int i = 0; i < 2; i++) begin
        if (w[i] > cfg.on_threshold) begin
          latch_next[i] = 1'b1;
        end else if (w[i] < cfg.off_threshold) begin
          latch_next[i] = 1'b0;
        end
      end
      if (w[2] < cfg.off_threshold) begin
        r3 = 1'b1;
      end else if (w[2] > cfg.on_threshold) begin
        r4 = 1'b1;
      end
    end

    result.relay_one   = latch_next[0];
    result.relay_two   = latch_next[1];
    result.relay_three = r3;
    result.relay_four  = r4;
    result.armed       = armed_next;
    result.signal_ok   = valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        held[i] <= rcps_pkg::RST_CENTER_WIDTH;
      end
      last_good <= '0;
      armed     <= 1'b0;
      latch     <= 2'b00;
    end else if (fire) begin
      for (int i = 0; i < 3; i++) begin
        held[i] <= held_next[i];
      end
      last_good <= last_good_next;
      armed     <= armed_next;
      latch     <= latch_next;
    end
  end

endmodule

`default_nettype wire

[rtl/rc_pulse_relay_switch_failsafe_unit.sv]
// ----------------------------------------------------------------------------
// rc_pulse_relay_switch_failsafe_unit
// RC pulse relay switch with failsafe: input register, state update, result
// register and configuration registers.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output side does not
// stall, and returns one result per item. Each item is captured in an input
// register, then held widths, failsafe timer, arming flag and relay latches
// are updated as the item moves on and its result is placed in an output
// register. The input register keeps taking items while a result waits to be
// taken, as long as the item ahead of it can move on. The state update done
// as each item moves on sets the rate of one item per cycle. Configuration
// registers are written through cfg_write, cfg_index and cfg_data; the user
// must write them only while no item is in flight; the block does not enforce
// this. TIME_WIDTH sets how many low bits of now_ms the failsafe timer uses.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pulse_relay_switch_failsafe_unit #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire rcps_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output rcps_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_write,
  input  wire logic [rcps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [rcps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  rcps_pkg::cfg_t      cfg;
  rcps_pkg::in_item_t  in_reg;
  rcps_pkg::out_item_t result;
  logic                in_full;
  logic                move;
  logic                accept;

  // item moves from the input register once the output register is free
  assign move     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !move;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data <= result;
    end
  end

  rcps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rcps_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (move),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

endmodule

`default_nettype wire
